@@ design/pcm_sample_format_converter_unit_macros.svh @@
// assertion macros for the converter modules; only the queue uses them
`ifndef PCM_SAMPLE_FORMAT_CONVERTER_UNIT_MACROS_SVH
`define PCM_SAMPLE_FORMAT_CONVERTER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define PCMC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcmc assertion failed");

// next-cycle implication, checked out of reset
`define PCMC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcmc assertion failed");

`endif

@@ design/pcmc_pkg.sv @@
// shared types, constants and helper functions of the pcm format converter
`default_nettype none
package pcmc_pkg;

  // format codes
  localparam logic [2:0] FMT_I8  = 3'd0;
  localparam logic [2:0] FMT_I16 = 3'd1;
  localparam logic [2:0] FMT_I24 = 3'd2;
  localparam logic [2:0] FMT_I32 = 3'd3;
  localparam logic [2:0] FMT_F32 = 3'd4;
  localparam logic [2:0] FMT_F64 = 3'd5;

  // register indexes
  localparam logic [2:0] REG_IN_FORMAT     = 3'd0;
  localparam logic [2:0] REG_OUT_FORMAT    = 3'd1;
  localparam logic [2:0] REG_CHANNEL_COUNT = 3'd2;
  localparam logic [2:0] REG_FRAME_COUNT   = 3'd3;
  localparam logic [2:0] REG_FRAME_STEP    = 3'd4;
  localparam logic [2:0] REG_CHANNEL_STEP  = 3'd5;
  localparam logic [2:0] REG_OUT_BASE      = 3'd6;

  // buffer geometry
  localparam int MAX_CHANNELS = 64;
  localparam int MAX_FRAMES   = 4096;
  localparam int CH_W         = $clog2(MAX_CHANNELS);
  localparam int FR_W         = $clog2(MAX_FRAMES);

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // product widths of the address terms
  localparam int CPROD_W = 19;
  localparam int FPROD_W = 19;

  typedef struct packed {
    logic [2:0]  in_format;
    logic [2:0]  out_format;
    logic [6:0]  channel_count;
    logic [12:0] frame_count;
    logic [6:0]  out_frame_step;
    logic [12:0] out_channel_step;
    logic [17:0] out_base;
  } cfg_t;

  typedef struct packed {
    logic [63:0]        sample;
    logic [CPROD_W-1:0] cprod;
    logic [FPROD_W-1:0] fprod;
    logic               last;
  } qent_t;

  // sample width of a format
  function automatic logic [6:0] fmt_bits(input logic [2:0] f);
    logic [6:0] b;
    case (f)
      FMT_I8:  b = 7'd8;
      FMT_I16: b = 7'd16;
      FMT_I24: b = 7'd24;
      FMT_I32: b = 7'd32;
      FMT_F32: b = 7'd32;
      default: b = 7'd64;
    endcase
    return b;
  endfunction

  // low ones mask of a width
  function automatic logic [63:0] width_mask(input logic [6:0] bits);
    logic [63:0] m;
    if (bits >= 7'd64) m = '1;
    else m = (64'd1 << bits) - 64'd1;
    return m;
  endfunction

  // sign extend a right aligned integer sample
  function automatic logic [63:0] sext(input logic [63:0] raw, input logic [6:0] bits);
    logic [63:0] v;
    logic [63:0] sg;
    v  = raw & width_mask(bits);
    sg = 64'd1 << (bits - 7'd1);
    return (v ^ sg) - sg;
  endfunction

endpackage
`default_nettype wire

@@ design/pcm_sample_format_converter_unit.sv @@
// top level of the pcm sample format converter with its register file
//
//   channel  | ports                                   | beat moves
//   ---------+-----------------------------------------+---------------------------
//   input    | push, full, in_sample_in                | one raw sample
//   result   | pop, empty, out_sample_out,             | converted sample, address,
//            | out_out_address, out_end_of_buffer      | end of buffer flag
//   config   | psel, penable, pwrite, paddr, pwdata,   | one register write or read
//            | prdata, pready                          |
//
// one sample per cycle sustained while results are popped; a taken beat is
// queued, read into the classify stage, then converted into the result register
// the four-entry queue takes input beats while the result side is stalled
// full rises only when the queue holds four samples and the pipeline is blocked
// reset is synchronous: positions go to zero and registers to their reset values
`default_nettype none
module pcm_sample_format_converter_unit
  import pcmc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [63:0] in_sample_in,
  input  wire logic        pop,
  output logic             empty,
  output logic [63:0]      out_sample_out,
  output logic [17:0]      out_out_address,
  output logic             out_end_of_buffer,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t  cfg_r;
  qent_t wr_data, rd_data;
  logic  q_wr, q_rd, q_full, q_empty;
  logic  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.in_format        <= FMT_I16;
      cfg_r.out_format       <= FMT_I16;
      cfg_r.channel_count    <= 7'd2;
      cfg_r.frame_count      <= 13'd256;
      cfg_r.out_frame_step   <= 7'd2;
      cfg_r.out_channel_step <= 13'd1;
      cfg_r.out_base         <= 18'd0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_IN_FORMAT:     cfg_r.in_format        <= pwdata[2:0];
        REG_OUT_FORMAT:    cfg_r.out_format       <= pwdata[2:0];
        REG_CHANNEL_COUNT: cfg_r.channel_count    <= pwdata[6:0];
        REG_FRAME_COUNT:   cfg_r.frame_count      <= pwdata[12:0];
        REG_FRAME_STEP:    cfg_r.out_frame_step   <= pwdata[6:0];
        REG_CHANNEL_STEP:  cfg_r.out_channel_step <= pwdata[12:0];
        REG_OUT_BASE:      cfg_r.out_base         <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[4:2])
      REG_IN_FORMAT:     prdata = 32'(cfg_r.in_format);
      REG_OUT_FORMAT:    prdata = 32'(cfg_r.out_format);
      REG_CHANNEL_COUNT: prdata = 32'(cfg_r.channel_count);
      REG_FRAME_COUNT:   prdata = 32'(cfg_r.frame_count);
      REG_FRAME_STEP:    prdata = 32'(cfg_r.out_frame_step);
      REG_CHANNEL_STEP:  prdata = 32'(cfg_r.out_channel_step);
      REG_OUT_BASE:      prdata = 32'(cfg_r.out_base);
      default:           prdata = '0;
    endcase
  end

  assign full = q_full;

  // front part
  pcmc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .push   (push),
    .sample (in_sample_in),
    .q_full (q_full),
    .q_wr   (q_wr),
    .q_data (wr_data)
  );

  // queue between the parts
  pcmc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_data (wr_data),
    .full    (q_full),
    .rd      (q_rd),
    .rd_data (rd_data),
    .empty   (q_empty)
  );

  // back part
  pcmc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_data      (rd_data),
    .q_empty     (q_empty),
    .q_rd        (q_rd),
    .res_sample  (out_sample_out),
    .res_address (out_out_address),
    .res_last    (out_end_of_buffer),
    .res_empty   (empty),
    .res_pop     (pop)
  );

endmodule
`default_nettype wire

@@ design/pcmc_fifo.sv @@
// short queue of samples and their address terms between front and back
`default_nettype none
`include "pcm_sample_format_converter_unit_macros.svh"
module pcmc_fifo
  import pcmc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  wr,
  input  wire qent_t wr_data,
  output logic       full,
  input  wire logic  rd,
  output qent_t      rd_data,
  output logic       empty
);

  qent_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_wr, do_rd;

  assign full    = (count_r == (QPTR_W+1)'(QDEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem_r[rptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wptr_r] <= wr_data;
  end

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd) count_nxt = count_r + 1'b1;
    else if (do_rd && !do_wr) count_nxt = count_r - 1'b1;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_wr) wptr_r <= wptr_r + 1'b1;
      if (do_rd) rptr_r <= rptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  // checks
  `PCMC_ASSERT_NXT(a_grow, do_wr && !do_rd, count_r == $past(count_r) + 1'b1)
  `PCMC_ASSERT_NXT(a_shrink, do_rd && !do_wr, count_r == $past(count_r) - 1'b1)
  `PCMC_ASSERT_IMP(a_ptr_gap, 1'b1, (wptr_r - rptr_r) == count_r[QPTR_W-1:0])

endmodule
`default_nettype wire

@@ design/pcmc_front.sv @@
// front: accepts samples, tracks buffer position and forms address terms
`default_nettype none
module pcmc_front
  import pcmc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        push,
  input  wire logic [63:0] sample,
  input  wire logic        q_full,
  output logic             q_wr,
  output qent_t            q_data
);

  logic [CH_W-1:0] ch_r, ch_nxt;
  logic [FR_W-1:0] fr_r, fr_nxt;
  logic [6:0]      chans;
  logic [12:0]     frames;
  logic            ch_wrap, fr_wrap;

  // clamped counts
  always_comb begin
    if (cfg.channel_count == '0) chans = 7'd1;
    else if (cfg.channel_count > 7'(MAX_CHANNELS)) chans = 7'(MAX_CHANNELS);
    else chans = cfg.channel_count;
    if (cfg.frame_count == '0) frames = 13'd1;
    else if (cfg.frame_count > 13'(MAX_FRAMES)) frames = 13'(MAX_FRAMES);
    else frames = cfg.frame_count;
  end

  assign ch_wrap = (7'(ch_r) + 7'd1) >= chans;
  assign fr_wrap = (13'(fr_r) + 13'd1) >= frames;
  assign q_wr    = push && !q_full;

  // queue entry
  always_comb begin
    q_data.sample = sample;
    q_data.cprod  = CPROD_W'(ch_r) * CPROD_W'(cfg.out_channel_step);
    q_data.fprod  = FPROD_W'(fr_r) * FPROD_W'(cfg.out_frame_step);
    q_data.last   = ch_wrap && fr_wrap;
  end

  // position advance
  always_comb begin
    ch_nxt = ch_r;
    fr_nxt = fr_r;
    if (q_wr) begin
      if (ch_wrap) begin
        ch_nxt = '0;
        fr_nxt = fr_wrap ? '0 : fr_r + 1'b1;
      end else begin
        ch_nxt = ch_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r <= '0;
      fr_r <= '0;
    end else begin
      ch_r <= ch_nxt;
      fr_r <= fr_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/pcmc_back.sv @@
// back: two stage format conversion pipeline ending in the result register
`default_nettype none
module pcmc_back
  import pcmc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire qent_t       q_data,
  input  wire logic        q_empty,
  output logic             q_rd,
  output logic [63:0]      res_sample,
  output logic [17:0]      res_address,
  output logic             res_last,
  output logic             res_empty,
  input  wire logic        res_pop
);

  // work kinds left for the second stage
  localparam logic [2:0] K_DONE   = 3'd0;
  localparam logic [2:0] K_NORM64 = 3'd1;
  localparam logic [2:0] K_NORM32 = 3'd2;
  localparam logic [2:0] K_F2I    = 3'd3;
  localparam logic [2:0] K_NARROW = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic        sign;
    logic [63:0] res;
    logic [31:0] w;
    logic [4:0]  p;
    logic [10:0] eoff;
    logic [52:0] sig;
    logic [4:0]  k;
    logic        nrm;
    logic [5:0]  shc;
    logic [6:0]  bo;
    logic [17:0] addr;
    logic        last;
  } s1_t;

  s1_t         s1_r, s1_nxt;
  logic        v1_r, v2_r;
  logic [63:0] s2_sample_r, s2_sample_nxt;
  logic [17:0] s2_addr_r;
  logic        s2_last_r;
  logic        s1_ready, s2_ready;

  // stage one: classify, integer paths, leading one search
  always_comb begin
    logic [2:0]         fi, fo;
    logic [6:0]         bi, bo;
    logic [63:0]        raw, x;
    logic [31:0]        a;
    logic [11:0]        e12, bias12;
    logic               neg, is_nan, is_zero;
    logic signed [12:0] es, ek, eb, t;
    logic [7:0]         e8;
    logic [22:0]        m23;
    logic [10:0]        e11;
    logic [51:0]        m52;
    logic [19:0]        asum;
    fi  = cfg.in_format;
    fo  = cfg.out_format;
    bi  = fmt_bits(fi);
    bo  = fmt_bits(fo);
    raw = q_data.sample;
    x   = sext(raw, bi);
    e8  = raw[30:23];
    m23 = raw[22:0];
    e11 = raw[62:52];
    m52 = raw[51:0];
    a   = '0;
    e12 = '0;
    bias12 = '0;
    neg = 1'b0;
    is_nan = 1'b0;
    is_zero = 1'b0;
    es = '0;
    ek = '0;
    eb = '0;
    t  = '0;
    s1_nxt = '0;
    s1_nxt.kind = K_DONE;
    s1_nxt.bo   = bo;
    asum = 20'(cfg.out_base) + 20'(q_data.cprod) + 20'(q_data.fprod);
    s1_nxt.addr = asum[17:0];
    s1_nxt.last = q_data.last;

    if (fi > FMT_F64 || fo > FMT_F64) begin
      s1_nxt.res = '0;
    end else if (fi == fo) begin
      s1_nxt.res = raw & width_mask(bo);
    end else if (fi < FMT_F32 && fo < FMT_F32) begin
      // integer to integer
      if (bi < bo) s1_nxt.res = (x << (bo - bi)) & width_mask(bo);
      else s1_nxt.res = 64'($signed(x) >>> (bi - bo)) & width_mask(bo);
    end else if (fi < FMT_F32) begin
      // integer to float, magnitude goes to normalize
      neg = x[63];
      a = neg ? (32'd0 - x[31:0]) : x[31:0];
      s1_nxt.w    = a;
      s1_nxt.sign = neg;
      if (fo == FMT_F64) begin
        s1_nxt.kind = K_NORM64;
        s1_nxt.eoff = 11'd1024 - 11'(bi);
      end else begin
        s1_nxt.kind = K_NORM32;
        s1_nxt.eoff = 11'd128 - 11'(bi);
      end
    end else if (fo < FMT_F32) begin
      // float to integer
      if (fi == FMT_F32) begin
        neg = raw[31];
        e12 = 12'(e8);
        bias12 = 12'd127;
        is_nan = (e8 == 8'hFF) && (m23 != '0);
        is_zero = (e8 == '0);
        s1_nxt.sig = {1'b1, m23, 29'd0};
      end else begin
        neg = raw[63];
        e12 = 12'(e11);
        bias12 = 12'd1023;
        is_nan = (e11 == 11'h7FF) && (m52 != '0);
        is_zero = (e11 == '0);
        s1_nxt.sig = {1'b1, m52};
      end
      es = $signed({1'b0, e12}) - $signed({1'b0, bias12});
      ek = es + $signed({6'd0, bo}) - 13'sd1;
      s1_nxt.sign = neg;
      if (is_nan || is_zero) s1_nxt.res = '0;
      else if (es >= 13'sd0) s1_nxt.res = neg ? (64'd1 << (bo - 7'd1)) : (width_mask(bo) >> 1);
      else if (ek < 13'sd0) s1_nxt.res = '0;
      else begin
        s1_nxt.kind = K_F2I;
        s1_nxt.k = ek[4:0];
      end
    end else if (fi == FMT_F32) begin
      // float32 to float64
      if (e8 == 8'hFF && m23 != '0)
        s1_nxt.res = {raw[31], 11'h7FF, {1'b1, 51'd0} | {m23, 29'd0}};
      else if (e8 == 8'hFF)
        s1_nxt.res = {raw[31], 11'h7FF, 52'd0};
      else if (e8 == '0 && m23 == '0)
        s1_nxt.res = {raw[31], 63'd0};
      else if (e8 == '0) begin
        s1_nxt.kind = K_NORM64;
        s1_nxt.w    = {9'd0, m23};
        s1_nxt.sign = raw[31];
        s1_nxt.eoff = 11'd874;
      end else
        s1_nxt.res = {raw[31], 11'(e8) + 11'd896, m23, 29'd0};
    end else begin
      // float64 to float32
      if (e11 == 11'h7FF && m52 != '0)
        s1_nxt.res = {32'd0, raw[63], 8'hFF, {1'b1, 22'd0} | m52[51:29]};
      else if (e11 >= 11'd1151)
        s1_nxt.res = {32'd0, raw[63], 8'hFF, 23'd0};
      else if (e11 == '0)
        s1_nxt.res = {32'd0, raw[63], 31'd0};
      else begin
        eb = $signed({2'd0, e11}) - 13'sd896;
        t  = 13'sd30 - eb;
        s1_nxt.kind = K_NARROW;
        s1_nxt.sign = raw[63];
        s1_nxt.sig  = {1'b1, m52};
        s1_nxt.eoff = 11'(eb[7:0]);
        s1_nxt.nrm  = (eb >= 13'sd1);
        s1_nxt.shc  = (t > 13'sd56) ? 6'd56 : t[5:0];
      end
    end

    // leading one of the magnitude
    for (int i = 0; i < 32; i++) begin
      if (s1_nxt.w[i]) s1_nxt.p = 5'(i);
    end
  end

  // stage two: normalize, round, shift out
  always_comb begin
    logic [31:0]  n;
    logic [10:0]  ex;
    logic [30:0]  q;
    logic [63:0]  mag;
    logic [108:0] wide;
    logic [22:0]  frac;
    logic         g, st;
    n    = s1_r.w << (5'd31 - s1_r.p);
    ex   = s1_r.eoff + 11'(s1_r.p);
    q    = '0;
    mag  = '0;
    wide = '0;
    frac = '0;
    g    = 1'b0;
    st   = 1'b0;
    case (s1_r.kind)
      K_DONE: s2_sample_nxt = s1_r.res;
      K_NORM64: begin
        if (s1_r.w == '0) s2_sample_nxt = '0;
        else s2_sample_nxt = {s1_r.sign, ex, n[30:0], 21'd0};
      end
      K_NORM32: begin
        q = {ex[7:0], n[30:8]} + 31'(n[7] & (n[8] | (|n[6:0])));
        if (s1_r.w == '0) s2_sample_nxt = '0;
        else s2_sample_nxt = {32'd0, s1_r.sign, q};
      end
      K_F2I: begin
        mag = 64'(s1_r.sig) >> (6'd52 - 6'(s1_r.k));
        s2_sample_nxt = (s1_r.sign ? (64'd0 - mag) : mag) & width_mask(s1_r.bo);
      end
      K_NARROW: begin
        if (s1_r.nrm) begin
          q = {s1_r.eoff[7:0], s1_r.sig[51:29]}
            + 31'(s1_r.sig[28] & (s1_r.sig[29] | (|s1_r.sig[27:0])));
        end else begin
          wide = {s1_r.sig, 56'd0} >> s1_r.shc;
          frac = wide[78:56];
          g    = wide[55];
          st   = |wide[54:0];
          q    = {8'd0, frac} + 31'(g & (frac[0] | st));
        end
        s2_sample_nxt = {32'd0, s1_r.sign, q};
      end
      default: s2_sample_nxt = '0;
    endcase
  end

  // pipeline flow
  assign s2_ready  = !v2_r || res_pop;
  assign s1_ready  = !v1_r || s2_ready;
  assign q_rd      = !q_empty && s1_ready;
  assign res_empty = !v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (s1_ready) v1_r <= q_rd;
      if (s2_ready) v2_r <= v1_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s1_ready) s1_r <= s1_nxt;
    if (s2_ready) begin
      s2_sample_r <= s2_sample_nxt;
      s2_addr_r   <= s1_r.addr;
      s2_last_r   <= s1_r.last;
    end
  end

  assign res_sample  = s2_sample_r;
  assign res_address = s2_addr_r;
  assign res_last    = s2_last_r;

endmodule
`default_nettype wire

@@ sim/pcm_sample_format_converter_unit_tb.sv @@
// self-checking testbench of the pcm sample format converter
`timescale 1ns / 1ps
module pcm_sample_format_converter_unit_tb;
  import pcmc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int BLOCKS = 65;
  localparam int BLOCK_BEATS = 30;

  typedef struct {
    logic [63:0] sample;
    logic [17:0] addr;
    logic        last;
  } conv_result_t;

  typedef struct {
    logic [2:0]  fi;
    logic [2:0]  fo;
    logic [63:0] sample;
    bit          typed;
    logic [63:0] want;
  } directed_row_t;

  logic clk, rst_n;
  logic push, pop, psel, penable, pwrite;
  logic [63:0] in_sample_in;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  wire         full, empty, pready;
  wire  [63:0] out_sample_out;
  wire  [17:0] out_out_address;
  wire         out_end_of_buffer;
  wire  [31:0] prdata;

  // typed expectation riding along with a directed beat
  logic        typed_en;
  logic [63:0] typed_val;

  pcm_sample_format_converter_unit dut (
    .clk, .rst_n, .push, .full, .in_sample_in, .pop, .empty, .out_sample_out,
    .out_out_address, .out_end_of_buffer, .psel, .penable, .pwrite, .paddr,
    .pwdata, .prdata, .pready
  );

  // shadow of the register file and buffer positions
  logic [2:0]  sh_in_fmt, sh_out_fmt;
  logic [6:0]  sh_chans;
  logic [12:0] sh_frames;
  logic [6:0]  sh_fstep;
  logic [12:0] sh_cstep;
  logic [17:0] sh_base;
  int          ch_pos, fr_pos;

  conv_result_t pending_results[$];
  int errors;
  int cycles;
  int snd_pct, rcv_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int fmt_width(logic [2:0] f);
    case (f)
      FMT_I8:  return 8;
      FMT_I16: return 16;
      FMT_I24: return 24;
      FMT_I32: return 32;
      FMT_F32: return 32;
      default: return 64;
    endcase
  endfunction

  function automatic logic [63:0] low_ones(int bits);
    if (bits >= 64) return '1;
    return (64'd1 << bits) - 64'd1;
  endfunction

  // exact widening of float32 bits to float64 bits
  function automatic logic [63:0] widen_f32(logic [31:0] b);
    logic [23:0] mm;
    logic [10:0] ex;
    if (b[30:23] == 8'hFF) return {b[31], 11'h7FF, b[22:0], 29'd0};
    if (b[30:23] == 8'h00) begin
      if (b[22:0] == 23'd0) return {b[31], 63'd0};
      mm = {1'b0, b[22:0]};
      ex = 11'd897;
      while (!mm[23]) begin
        mm = mm << 1;
        ex = ex - 11'd1;
      end
      return {b[31], ex, mm[22:0], 29'd0};
    end
    return {b[31], 11'(b[30:23] + 11'd896), b[22:0], 29'd0};
  endfunction

  // float64 bits to float32 bits, round to nearest even
  function automatic logic [31:0] narrow_f64(logic [63:0] r);
    int          e, sh;
    logic [63:0] sig, base, rem, half;
    if (r[62:52] == 11'd0) return {r[63], 31'd0};
    e = int'(r[62:52]) - 1023;
    sig = {11'd0, 1'b1, r[51:0]};
    if (e > 127) return {r[63], 8'hFF, 23'd0};
    if (e >= -126) begin
      sh = 29;
      base = (64'(e + 127) << 23) | ((sig >> 29) & 64'h7FFFFF);
    end else begin
      sh = 29 + (-126 - e);
      if (sh >= 55) return {r[63], 31'd0};
      base = sig >> sh;
    end
    rem = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && base[0])) base = base + 64'd1;
    return {r[63], base[30:0]};
  endfunction

  // converted bits of one sample under the current formats
  function automatic logic [63:0] convert_sample(logic [63:0] raw, logic [2:0] fi,
                                                 logic [2:0] fo);
    int          bi, bo;
    logic [63:0] x;
    longint      r;
    real         d, v, lim, a;
    bit          is_nan;
    bi = fmt_width(fi);
    bo = fmt_width(fo);
    if (fi > FMT_F64 || fo > FMT_F64) return 64'd0;
    if (fi == fo) return raw & low_ones(bo);
    // integer to integer
    if (fi < FMT_F32 && fo < FMT_F32) begin
      x = raw & low_ones(bi);
      if (x[bi-1]) x = x | ~low_ones(bi);
      if (bi < bo) return (x << (bo - bi)) & low_ones(bo);
      return 64'($signed(x) >>> (bi - bo)) & low_ones(bo);
    end
    // integer to float
    if (fi < FMT_F32) begin
      x = raw & low_ones(bi);
      if (x[bi-1]) x = x | ~low_ones(bi);
      d = real'($signed(x)) / (2.0 ** (bi - 1));
      if (fo == FMT_F64) return $realtobits(d);
      return {32'd0, narrow_f64($realtobits(d))};
    end
    // float to integer
    if (fo < FMT_F32) begin
      if (fi == FMT_F32) begin
        is_nan = raw[30:23] == 8'hFF && raw[22:0] != 23'd0;
        d = $bitstoreal(widen_f32(raw[31:0]));
      end else begin
        is_nan = raw[62:52] == 11'h7FF && raw[51:0] != 52'd0;
        d = $bitstoreal(raw);
      end
      if (is_nan) return 64'd0;
      lim = 2.0 ** (bo - 1);
      v = d * lim;
      if (v >= lim) r = (64'sd1 <<< (bo - 1)) - 1;
      else if (v <= -lim) r = -(64'sd1 <<< (bo - 1));
      else r = $rtoi(v);
      return 64'(r) & low_ones(bo);
    end
    // float32 to float64
    if (fi == FMT_F32) begin
      if (raw[30:23] == 8'hFF && raw[22:0] != 23'd0)
        return {raw[31], 63'h7FF8000000000000 | (63'(raw[22:0]) << 29)};
      return widen_f32(raw[31:0]);
    end
    // float64 to float32
    if (raw[62:52] == 11'h7FF && raw[51:0] != 52'd0)
      return {32'd0, raw[63], 31'h7FC00000 | 31'(raw[51:29])};
    d = $bitstoreal(raw);
    a = d < 0.0 ? -d : d;
    if (a >= (2.0 - 2.0 ** (-24)) * 2.0 ** 127) return {32'd0, raw[63], 31'h7F800000};
    if (a > (2.0 - 2.0 ** (-23)) * 2.0 ** 127) return {32'd0, raw[63], 31'h7F7FFFFF};
    return {32'd0, narrow_f64(raw)};
  endfunction

  // converted sample, address and buffer flag for the next sample, then advance positions
  function automatic conv_result_t next_result(logic [63:0] raw);
    conv_result_t res;
    int chans, frames;
    chans = sh_chans < 1 ? 1 : (sh_chans > MAX_CHANNELS ? MAX_CHANNELS : sh_chans);
    frames = sh_frames < 1 ? 1 : (sh_frames > MAX_FRAMES ? MAX_FRAMES : sh_frames);
    res.sample = convert_sample(raw, sh_in_fmt, sh_out_fmt);
    res.addr = 18'(sh_base + ch_pos * sh_cstep + fr_pos * sh_fstep);
    res.last = 1'b0;
    if (ch_pos + 1 >= chans) begin
      ch_pos = 0;
      if (fr_pos + 1 >= frames) begin
        fr_pos = 0;
        res.last = 1'b1;
      end else fr_pos++;
    end else ch_pos++;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // sample beats and result beats at the rising edge
  always @(posedge clk) begin
    conv_result_t exp_res;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
    if (rst_n) begin
      if (pop && !empty) begin
        if (pending_results.size() == 0) report_mismatch("unexpected beat", out_sample_out, 0);
        else begin
          exp_res = pending_results.pop_front();
          if (out_sample_out !== exp_res.sample)
            report_mismatch("sample", out_sample_out, exp_res.sample);
          if (out_out_address !== exp_res.addr)
            report_mismatch("address", 64'(out_out_address), 64'(exp_res.addr));
          if (out_end_of_buffer !== exp_res.last)
            report_mismatch("end of buffer", 64'(out_end_of_buffer), 64'(exp_res.last));
        end
      end
      if (push && !full) begin
        exp_res = next_result(in_sample_in);
        if (typed_en) exp_res.sample = typed_val;
        pending_results.insert(pending_results.size(), exp_res);
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) pop <= rst_n && ($urandom_range(99) >= rcv_pct);

  // register write, setup then access; called at a falling edge
  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 5'(idx) << 2; pwdata <= val;
    @(negedge clk) penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
    case (idx)
      REG_IN_FORMAT:     sh_in_fmt = val[2:0];
      REG_OUT_FORMAT:    sh_out_fmt = val[2:0];
      REG_CHANNEL_COUNT: sh_chans = val[6:0];
      REG_FRAME_COUNT:   sh_frames = val[12:0];
      REG_FRAME_STEP:    sh_fstep = val[6:0];
      REG_CHANNEL_STEP:  sh_cstep = val[12:0];
      default:           sh_base = val[17:0];
    endcase
    @(negedge clk);
  endtask

  // one input beat with random sender gaps; called and returns at a falling edge
  task automatic send_sample(logic [63:0] data, bit typed, logic [63:0] want);
    while ($urandom_range(99) < snd_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1; in_sample_in <= data;
    typed_en <= typed; typed_val <= want;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // hold off the sender until every result has come back
  task automatic drain();
    push <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  function automatic logic [63:0] random_sample(logic [2:0] fi);
    logic [63:0] s;
    s = {$urandom, $urandom};
    case ($urandom_range(9))
      4, 5, 6: begin
        if (fi == FMT_F32) s[30:23] = 8'($urandom_range(100, 130));
        else s[62:52] = 11'($urandom_range(1000, 1030));
      end
      7: begin
        if (fi == FMT_F32) s[30:0] = {8'hFF, 22'd0, 1'($urandom_range(1))};
        else s[62:0] = {11'h7FF, 51'd0, 1'($urandom_range(1))};
      end
      8: begin
        if (fi == FMT_F32) s[30:23] = 8'd0;
        else s[62:52] = 11'($urandom_range(1) ? 0 : $urandom_range(890, 930));
      end
      9: s[62:29] = 34'h23DFFFFFF;
      default: ;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] pick(int a, int b, int c, int lo, int hi);
    case ($urandom_range(4))
      0: return a;
      1: return b;
      2: return c;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  directed_row_t rows[$];

  initial begin
    errors = 0; cycles = 0;
    snd_pct = 0; rcv_pct = 0;
    rst_n = 1'b0; push = 1'b0; pop = 1'b0; psel = 1'b0; penable = 1'b0;
    pwrite = 1'b0; paddr = '0; pwdata = '0; in_sample_in = '0;
    typed_en = 1'b0; typed_val = '0;
    sh_in_fmt = FMT_I16; sh_out_fmt = FMT_I16; sh_chans = 7'd2; sh_frames = 13'd256;
    sh_fstep = 7'd2; sh_cstep = 13'd1; sh_base = 18'd0; ch_pos = 0; fr_pos = 0;
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    @(negedge clk);

    // directed: pass-through after reset, extremes, saturation, nan, unused codes
    rows = '{
      '{FMT_I16, FMT_I16, 64'h12345, 1, 64'h2345},
      '{FMT_I16, FMT_I8,  64'h7FFF, 1, 64'h7F},
      '{FMT_I8,  FMT_I32, 64'h80, 1, 64'h80000000},
      '{FMT_I32, FMT_I24, 64'hFFFF_FFFF_8000_0000, 1, 64'h800000},
      '{FMT_I24, FMT_I16, 64'h7FFFFF, 1, 64'h7FFF},
      '{FMT_I16, FMT_F32, 64'h8000, 1, 64'hBF800000},
      '{FMT_I8,  FMT_F64, 64'h7F, 0, 64'd0},
      '{FMT_I32, FMT_F32, 64'h7FFFFFFF, 0, 64'd0},
      '{FMT_F64, FMT_I16, 64'h4000000000000000, 1, 64'h7FFF},
      '{FMT_F64, FMT_I16, 64'hC000000000000000, 1, 64'h8000},
      '{FMT_F64, FMT_I32, 64'h7FF8000000000001, 1, 64'd0},
      '{FMT_F32, FMT_I8,  64'hBF000000, 0, 64'd0},
      '{FMT_F32, FMT_I24, 64'h7F800000, 1, 64'h7FFFFF},
      '{FMT_F32, FMT_F64, 64'h7FC00001, 1, 64'h7FF8000020000000},
      '{FMT_F32, FMT_F64, 64'h00000001, 0, 64'd0},
      '{FMT_F64, FMT_F32, 64'h7FEFFFFFFFFFFFFF, 1, 64'h7F800000},
      '{FMT_F64, FMT_F32, 64'h47EFFFFFDFFFFFFF, 0, 64'd0},
      '{FMT_F64, FMT_F32, 64'h3690000000000001, 0, 64'd0},
      '{FMT_F64, FMT_F32, 64'hFFF0000000000001, 1, 64'hFFC00000},
      '{FMT_F64, FMT_F64, 64'hFFFFFFFFFFFFFFFF, 1, 64'hFFFFFFFFFFFFFFFF},
      '{3'd6,    FMT_I16, 64'h1234, 1, 64'd0},
      '{FMT_I8,  3'd7,    64'h12, 1, 64'd0}
    };
    foreach (rows[i]) begin
      if (rows[i].fi != sh_in_fmt || rows[i].fo != sh_out_fmt) begin
        drain();
        cfg_write(REG_IN_FORMAT, 32'(rows[i].fi));
        cfg_write(REG_OUT_FORMAT, 32'(rows[i].fo));
      end
      send_sample(rows[i].sample, rows[i].typed, rows[i].want);
    end

    // random blocks, each under a fresh register setting written while idle
    for (int blk = 0; blk < BLOCKS; blk++) begin
      drain();
      case (blk % 4)
        0: begin snd_pct = 0; rcv_pct = 0; end
        1: begin snd_pct = 51; rcv_pct = 0; end
        2: begin snd_pct = 0; rcv_pct = 51; end
        default: begin snd_pct = 22; rcv_pct = 22; end
      endcase
      cfg_write(REG_IN_FORMAT, $urandom_range(9) == 0 ? $urandom_range(7, 6) : $urandom_range(5));
      cfg_write(REG_OUT_FORMAT, $urandom_range(9) == 0 ? $urandom_range(7, 6)
                                                       : $urandom_range(5));
      cfg_write(REG_CHANNEL_COUNT, pick(0, 64, 127, 1, 4));
      cfg_write(REG_FRAME_COUNT, pick(1, 4096, 8191, 0, 6));
      cfg_write(REG_FRAME_STEP, pick(0, 64, 127, 0, 127));
      cfg_write(REG_CHANNEL_STEP, pick(0, 4096, 8191, 0, 8191));
      cfg_write(REG_OUT_BASE, pick(0, 262143, 262100, 0, 262143));
      for (int k = 0; k < BLOCK_BEATS; k++) send_sample(random_sample(sh_in_fmt), 0, 64'd0);
    end

    drain();
    repeat (10) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
